FILE: hdl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

  localparam int CalW     = 16;
  localparam int RawW     = 24;
  localparam int OutW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int TempW    = 20;
  localparam int NumStages = 9;

  // Temperature thresholds in 0.01 degC
  localparam int TempRef     = 2000;   // 20.00 degC, low-temperature boundary
  localparam int VeryLowTemp = -1600;  // highest temperature that counts as very low
  localparam int VeryLowOfs  = 1500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgC1 = 3'd0,
    CfgC2 = 3'd1,
    CfgC3 = 3'd2,
    CfgC4 = 3'd3,
    CfgC5 = 3'd4,
    CfgC6 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

endpackage

FILE: hdl/ptc_intf.sv
// Valid/ready channel interfaces: calibration writes, raw conversion items,
// compensated result items. Depends on ptc_pkg.
interface ptc_cfg_if;
  import ptc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CalW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ptc_in_if;
  import ptc_pkg::*;
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_out_if;
  import ptc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] pressure_tenth_mbar;
  logic signed [OutW-1:0] temperature_centideg;
  modport source (output valid, pressure_tenth_mbar, temperature_centideg, input ready);
  modport sink   (input valid, pressure_tenth_mbar, temperature_centideg, output ready);
endinterface

FILE: hdl/ptc_cal_regs.sv
// Six 16-bit calibration word registers written over the config channel.
// Depends on ptc_pkg and ptc_cfg_if.
module ptc_cal_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptc_cfg_if.sink       cfg_i,
  output ptc_pkg::cal_t cal_o
);
  import ptc_pkg::*;

  cal_t cal_q, cal_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgC1: cal_d.c1 = cfg_i.data;
        CfgC2: cal_d.c2 = cfg_i.data;
        CfgC3: cal_d.c3 = cfg_i.data;
        CfgC4: cal_d.c4 = cfg_i.data;
        CfgC5: cal_d.c5 = cfg_i.data;
        CfgC6: cal_d.c6 = cfg_i.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

FILE: hdl/pressure_temperature_compensation.sv
// Top level: nine-stage second-order pressure/temperature compensation pipeline.
// Depends on ptc_pkg, ptc_intf (channel interfaces) and ptc_cal_regs.
//
// Takes one pair of raw 24-bit conversions (pressure D1, temperature D2) per
// item and returns pressure in 0.1 mbar and temperature in 0.01 degC, both
// 32-bit two's complement with wraparound. Throughput is one item per clock
// while the output is not stalled. The stage chain, in order: dT, the
// calibration multiplies, first-order scaling, branch squares, correction terms,
// differences, the D1 x sensitivity product and two truncating scale steps. Each
// stage stalls only when the one after it is full and stalled, so bubbles collapse
// and an item is accepted while a result waits at the output if a stage is free.
// Calibration words reset to zero and should be written while no item is in flight.
module pressure_temperature_compensation (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptc_cfg_if.sink   cfg_i,
  ptc_in_if.sink    in_i,
  ptc_out_if.source out_o
);
  import ptc_pkg::*;

  cal_t cal;

  ptc_cal_regs u_cal_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cal_o  (cal)
  );

  // ---------------- pipeline control ----------------
  logic [NumStages:1] vld_q, vld_d;
  logic [NumStages:1] en;

  always_comb begin
    en[NumStages] = !vld_q[NumStages] || out_o.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[1]) begin
      vld_d[1] = in_i.valid;
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = en[1];

  // ---------------- stage 1: dT ----------------
  logic [RawW-1:0]    s1_d1_q;
  logic signed [24:0] s1_dt_q, s1_dt_d;

  assign s1_dt_d = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_d1_q <= in_i.raw_pressure;
      s1_dt_q <= s1_dt_d;
    end
  end

  // ---------------- stage 2: calibration products ----------------
  logic [RawW-1:0]    s2_d1_q;
  logic signed [41:0] s2_c3dt_q, s2_c4dt_q, s2_c6dt_q;
  logic signed [41:0] s2_c3dt_d, s2_c4dt_d, s2_c6dt_d;
  logic signed [49:0] s2_dtsq_q, s2_dtsq_d;

  assign s2_c3dt_d = $signed({1'b0, cal.c3}) * s1_dt_q;
  assign s2_c4dt_d = $signed({1'b0, cal.c4}) * s1_dt_q;
  assign s2_c6dt_d = $signed({1'b0, cal.c6}) * s1_dt_q;
  assign s2_dtsq_d = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_d1_q   <= s1_d1_q;
      s2_c3dt_q <= s2_c3dt_d;
      s2_c4dt_q <= s2_c4dt_d;
      s2_c6dt_q <= s2_c6dt_d;
      s2_dtsq_q <= s2_dtsq_d;
    end
  end

  // ---------------- stage 3: first-order SENS, OFF, TEMP ----------------
  logic [RawW-1:0]       s3_d1_q;
  logic signed [34:0]    s3_sens_q, s3_sens_d;
  logic signed [35:0]    s3_off_q, s3_off_d;
  logic signed [TempW-1:0] s3_temp_q, s3_temp_d;
  logic [16:0]           s3_tilo_q, s3_tilo_d;
  logic [11:0]           s3_tihi_q, s3_tihi_d;
  logic signed [41:0]    c3_bias, c4_bias, c6_bias;
  logic [49:0]           dtsq3;

  // bias negative values so the arithmetic shift truncates toward zero
  assign c3_bias = s2_c3dt_q + (s2_c3dt_q[41] ? 42'sd255 : 42'sd0);
  assign c4_bias = s2_c4dt_q + (s2_c4dt_q[41] ? 42'sd127 : 42'sd0);
  assign c6_bias = s2_c6dt_q + (s2_c6dt_q[41] ? 42'sd8388607 : 42'sd0);

  assign s3_sens_d = $signed({4'b0, cal.c1, 15'b0}) + 35'(c3_bias >>> 8);
  assign s3_off_d  = $signed({4'b0, cal.c2, 16'b0}) + 36'(c4_bias >>> 7);
  assign s3_temp_d = TempW'(TempRef) + TempW'(c6_bias >>> 23);

  // dT^2 is non-negative and below 2^48
  assign dtsq3     = {2'b00, s2_dtsq_q[47:0]} + {1'b0, s2_dtsq_q[47:0], 1'b0};
  assign s3_tilo_d = dtsq3[49:33];
  assign s3_tihi_d = s2_dtsq_q[47:36];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_d1_q   <= s2_d1_q;
      s3_sens_q <= s3_sens_d;
      s3_off_q  <= s3_off_d;
      s3_temp_q <= s3_temp_d;
      s3_tilo_q <= s3_tilo_d;
      s3_tihi_q <= s3_tihi_d;
    end
  end

  // ---------------- stage 4: branch select, squares, temperature ----------------
  logic [RawW-1:0]        s4_d1_q;
  logic signed [34:0]     s4_sens_q;
  logic signed [35:0]     s4_off_q;
  logic                   s4_low_q, s4_low_d, s4_vlow_q, s4_vlow_d;
  logic [35:0]            s4_dsq_q, s4_esq_q;
  logic signed [OutW-1:0] s4_t_q, s4_t_d;
  logic signed [20:0]     dd, ee, t21;
  logic signed [41:0]     dsq_full, esq_full;
  logic [16:0]            ti_sel;

  assign s4_low_d  = s3_temp_q < TempW'(TempRef);
  assign s4_vlow_d = s3_temp_q <= TempW'(VeryLowTemp);
  assign dd        = 21'(s3_temp_q) - 21'(TempRef);
  assign ee        = 21'(s3_temp_q) + 21'(VeryLowOfs);
  assign dsq_full  = dd * dd;
  assign esq_full  = ee * ee;
  assign ti_sel    = s4_low_d ? s3_tilo_q : {5'b0, s3_tihi_q};
  assign t21       = 21'(s3_temp_q) - $signed({4'b0, ti_sel});
  assign s4_t_d    = OutW'(t21);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_d1_q   <= s3_d1_q;
      s4_sens_q <= s3_sens_q;
      s4_off_q  <= s3_off_q;
      s4_low_q  <= s4_low_d;
      s4_vlow_q <= s4_vlow_d;
      s4_dsq_q  <= dsq_full[35:0];
      s4_esq_q  <= esq_full[35:0];
      s4_t_q    <= s4_t_d;
    end
  end

  // ---------------- stage 5: correction terms, mod 2^32 ----------------
  logic [RawW-1:0]        s5_d1_q;
  logic signed [34:0]     s5_sens_q;
  logic signed [35:0]     s5_off_q;
  logic [31:0]            s5_offi_q, s5_offi_d, s5_sensi_q, s5_sensi_d;
  logic signed [OutW-1:0] s5_t_q;
  logic [37:0]            d3, d5;
  logic [31:0]            e7, e4;

  assign d3 = {2'b00, s4_dsq_q} + {1'b0, s4_dsq_q, 1'b0};
  assign d5 = {2'b00, s4_dsq_q} + {s4_dsq_q, 2'b00};
  assign e7 = {s4_esq_q[28:0], 3'b000} - s4_esq_q[31:0];
  assign e4 = {s4_esq_q[29:0], 2'b00};

  always_comb begin
    if (s4_low_q) begin
      s5_offi_d  = d3[32:1] + (s4_vlow_q ? e7 : 32'd0);
      s5_sensi_d = d5[34:3] + (s4_vlow_q ? e4 : 32'd0);
    end else begin
      s5_offi_d  = s4_dsq_q[35:4];
      s5_sensi_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_d1_q    <= s4_d1_q;
      s5_sens_q  <= s4_sens_q;
      s5_off_q   <= s4_off_q;
      s5_offi_q  <= s5_offi_d;
      s5_sensi_q <= s5_sensi_d;
      s5_t_q     <= s4_t_q;
    end
  end

  // ---------------- stage 6: corrected SENS and OFF ----------------
  logic [RawW-1:0]        s6_d1_q;
  logic signed [35:0]     s6_sdiff_q, s6_sdiff_d;
  logic signed [36:0]     s6_odiff_q, s6_odiff_d;
  logic signed [OutW-1:0] s6_t_q;

  assign s6_sdiff_d = 36'(s5_sens_q) - 36'($signed(s5_sensi_q));
  assign s6_odiff_d = 37'(s5_off_q) - 37'($signed(s5_offi_q));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_d1_q    <= s5_d1_q;
      s6_sdiff_q <= s6_sdiff_d;
      s6_odiff_q <= s6_odiff_d;
      s6_t_q     <= s5_t_q;
    end
  end

  // ---------------- stage 7: D1 x SENS ----------------
  logic signed [60:0]     s7_prod_q, s7_prod_d;
  logic signed [36:0]     s7_odiff_q;
  logic signed [OutW-1:0] s7_t_q;

  assign s7_prod_d = $signed({1'b0, s6_d1_q}) * s6_sdiff_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_prod_q  <= s7_prod_d;
      s7_odiff_q <= s6_odiff_q;
      s7_t_q     <= s6_t_q;
    end
  end

  // ---------------- stage 8: /2^21 minus OFF ----------------
  logic signed [40:0]     s8_q_q, s8_q_d;
  logic signed [OutW-1:0] s8_t_q;
  logic signed [60:0]     prod_bias;

  assign prod_bias = s7_prod_q + (s7_prod_q[60] ? 61'sd2097151 : 61'sd0);
  assign s8_q_d    = 41'(prod_bias >>> 21) - 41'(s7_odiff_q);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_q_q <= s8_q_d;
      s8_t_q <= s7_t_q;
    end
  end

  // ---------------- stage 9: /2^13, output register ----------------
  logic signed [OutW-1:0] s9_p_q, s9_p_d;
  logic signed [OutW-1:0] s9_t_q;
  logic signed [40:0]     q_bias;

  assign q_bias = s8_q_q + (s8_q_q[40] ? 41'sd8191 : 41'sd0);
  assign s9_p_d = OutW'(q_bias >>> 13);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_p_q <= s9_p_d;
      s9_t_q <= s8_t_q;
    end
  end

  assign out_o.valid                = vld_q[NumStages];
  assign out_o.pressure_tenth_mbar  = s9_p_q;
  assign out_o.temperature_centideg = s9_t_q;

  // ---------------- assertions ----------------
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[1])
    else $error("accepted item did not enter stage 1");

  a_stall_holds_s8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[9] && !out_o.ready && vld_q[8] |=> vld_q[8] && $stable(s8_q_q))
    else $error("stage 8 lost or changed its item under output stall");

  a_vlow_in_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && s4_vlow_q |-> s4_low_q)
    else $error("very-low branch flagged outside low branch");

endmodule
